// ----- hw/rtl/ovn_pkg.sv -----
// ============================================================================
// ovn_pkg
// Shared types, constants and the cosine weight table of the octave value
// noise core.
// ============================================================================
package ovn_pkg;

  localparam int MAX_OCT   = 8;
  localparam int FRAC_BITS = 16;
  localparam int TAB_BITS  = 8;
  localparam int TAB_SIZE  = 1 << TAB_BITS;
  localparam int OCT_W     = $clog2(MAX_OCT + 1);

  // Sample point scaled by the highest octave, with room for the lattice index.
  localparam int XI_W   = FRAC_BITS + 33 + MAX_OCT;
  localparam int MUL_W  = 35;
  localparam int PROD_W = 2 * MUL_W;
  localparam int AB_W   = 34;
  localparam int D_W    = 35;
  localparam int MIX_W  = 52;
  localparam int TOT_W  = 52;
  localparam int T30_W  = TOT_W - 18;
  localparam int RND_W  = 36;
  localparam int FIN_W  = 37;
  localparam int W_BITS = 17;

  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_B = 32'd789221;
  localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
  localparam int          HASH_SHIFT = 13;
  localparam logic signed [31:0] V_ONE = 32'sd1073741824;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_SIZE      = 3'd0;
  localparam logic [2:0] CFG_SCALE          = 3'd1;
  localparam logic [2:0] CFG_CENTER         = 3'd2;
  localparam logic [2:0] CFG_START_POSITION = 3'd3;
  localparam logic [2:0] CFG_OCTAVE_COUNT   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQ,
    ST_K,
    ST_X,
    ST_AB,
    ST_MIX,
    ST_ACC,
    ST_SCALE,
    ST_RND,
    ST_FIN
  } ovn_state_t;

  typedef logic [W_BITS-1:0] weight_t;
  typedef weight_t wtab_t [TAB_SIZE];

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint COS_DIV [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};

  // Truncated Taylor series of cos in Q30, evaluated at elaboration only.
  function automatic longint cos_q30(longint x);
    longint x2;
    longint c;
    int     k;
    x2 = (x * x) >>> 30;
    c  = Q30_ONE;
    for (k = 0; k < 6; k++) begin
      c = Q30_ONE - ((x2 * c) >>> 30) / COS_DIV[k];
    end
    return c;
  endfunction

  // Weight entry k is (1 - cos(pi*k/TAB_SIZE))/2 in Q16; upper half mirrored.
  function automatic wtab_t build_wtab();
    wtab_t  tab;
    longint theta;
    longint w;
    int     k;
    for (k = 0; k <= TAB_SIZE / 2; k++) begin
      theta = (PI_Q30 * longint'(k)) >>> TAB_BITS;
      w = (Q30_ONE - cos_q30(theta) + 64'sd16384) >>> 15;
      if (w < 0) begin
        w = 0;
      end
      if (w > 65536) begin
        w = 65536;
      end
      tab[k] = weight_t'(w);
    end
    for (k = TAB_SIZE / 2 + 1; k < TAB_SIZE; k++) begin
      tab[k] = weight_t'(65536) - tab[TAB_SIZE - k];
    end
    return tab;
  endfunction

  localparam wtab_t W_TAB = build_wtab();

  // Top TAB_BITS bits of the fraction, zero filled when the fraction is shorter.
  function automatic logic [TAB_BITS-1:0] table_idx(logic [FRAC_BITS-1:0] frac);
    logic [FRAC_BITS+TAB_BITS-1:0] ext;
    ext = {frac, {TAB_BITS{1'b0}}};
    return ext[FRAC_BITS+TAB_BITS-1 -: TAB_BITS];
  endfunction

  function automatic logic [31:0] hash_x(logic [31:0] n);
    return (n << HASH_SHIFT) ^ n;
  endfunction

endpackage

// ----- hw/rtl/octave_value_noise_1d_core.sv -----
// ============================================================================
// octave_value_noise_1d_core
// One-dimensional octave value noise with a stepping Q16.16 position.
// ============================================================================
// Every request advances the position by step_size and returns one Q16.16
// noise value for position plus sample_offset, summed over the configured
// number of octaves, at most eight. All arithmetic runs through one 35 by
// 35 bit multiplier under a small sequencer: each octave runs three multiplies
// for each of four lattice hashes, a smoothing step, the cosine blend multiply
// and the accumulate. A new request is taken while the previous result still
// waits in the output register. Configuration writes take effect at once;
// writing start_position also loads the position.
module octave_value_noise_1d_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ovn_pkg::ovn_state_t state_r, state_nxt;

  logic signed [31:0] step_r, scale_r, center_r;
  logic [3:0]         oct_cnt_r;
  logic [31:0]        position_r;
  logic signed [31:0] offset_r;

  logic signed [ovn_pkg::XI_W-1:0]   xi_r, xi_nxt;
  logic [ovn_pkg::OCT_W-1:0]         oct_r, oct_nxt, oct_lim_r, oct_lim_nxt, oct_inc;
  logic [1:0]                        pt_r, pt_nxt;
  logic [31:0]                       x_r, x_nxt;
  logic signed [31:0]                v_r [3];
  logic signed [31:0]                v_nxt [3];
  logic signed [ovn_pkg::AB_W-1:0]   a_r, a_nxt, b_val;
  logic signed [ovn_pkg::D_W-1:0]    d_r, d_nxt;
  logic signed [ovn_pkg::TOT_W-1:0]  total_r, total_nxt;
  logic signed [ovn_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ovn_pkg::RND_W-1:0]  rnd_r, rnd_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [31:0]                out_data_r, out_data_nxt;

  logic signed [ovn_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [31:0]                       base, lat, x_cur, hk, hv;
  logic signed [31:0]                v_cur;
  logic [ovn_pkg::W_BITS-1:0]        w_cur;
  logic signed [ovn_pkg::MIX_W-1:0]  mix, mix_sh;
  logic signed [ovn_pkg::T30_W-1:0]  t30;
  logic signed [ovn_pkg::PROD_W-1:0] rsum;
  logic signed [ovn_pkg::FIN_W-1:0]  fin;
  logic signed [31:0]                sat;
  logic                              accept;

  assign in_ready        = (state_r == ovn_pkg::ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_data_r;

  // Hash pipeline taps: lattice point base-1 .. base+2 selected by pt_r.
  assign base  = xi_r[ovn_pkg::FRAC_BITS +: 32];
  assign lat   = base + 32'(pt_r) - 32'd1;
  assign x_cur = ovn_pkg::hash_x(lat);
  assign hk    = prod_r[31:0] + ovn_pkg::HASH_ADD_B;
  assign hv    = prod_r[31:0] + ovn_pkg::HASH_ADD_C;
  assign v_cur = ovn_pkg::V_ONE - $signed({1'b0, hv[30:0]});

  assign w_cur  = ovn_pkg::W_TAB[ovn_pkg::table_idx(xi_r[ovn_pkg::FRAC_BITS-1:0])];
  assign mix    = (ovn_pkg::MIX_W'(a_r) <<< 16) + prod_r[ovn_pkg::MIX_W-1:0];
  assign mix_sh = mix >>> oct_r;
  assign t30    = total_r[ovn_pkg::TOT_W-1:18];
  assign rsum   = prod_r + (ovn_pkg::PROD_W'(1) <<< 29);
  assign fin    = ovn_pkg::FIN_W'(rnd_r) + ovn_pkg::FIN_W'(center_r);
  assign oct_inc = oct_r + ovn_pkg::OCT_W'(1);

  always_comb begin
    if (fin[ovn_pkg::FIN_W-1:31] != {(ovn_pkg::FIN_W-31){fin[ovn_pkg::FIN_W-1]}}) begin
      sat = fin[ovn_pkg::FIN_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = fin[31:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ovn_pkg::ST_SQ: begin
        mul_a = {3'b000, x_cur};
        mul_b = {3'b000, x_cur};
      end
      ovn_pkg::ST_K: begin
        mul_a = {3'b000, prod_r[31:0]};
        mul_b = {3'b000, ovn_pkg::HASH_MUL_A};
      end
      ovn_pkg::ST_X: begin
        mul_a = {3'b000, x_r};
        mul_b = {3'b000, hk};
      end
      ovn_pkg::ST_MIX: begin
        mul_a = d_r;
        mul_b = {{(ovn_pkg::MUL_W-ovn_pkg::W_BITS){1'b0}}, w_cur};
      end
      ovn_pkg::ST_SCALE: begin
        mul_a = ovn_pkg::MUL_W'(t30);
        mul_b = ovn_pkg::MUL_W'(scale_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Smoothed lattice values at n and n+1; the last hash arrives from prod_r.
  always_comb begin
    a_nxt = 2 * ovn_pkg::AB_W'(v_r[1]) + ovn_pkg::AB_W'(v_r[0]) + ovn_pkg::AB_W'(v_r[2]);
    b_val = 2 * ovn_pkg::AB_W'(v_r[2]) + ovn_pkg::AB_W'(v_r[1]) + ovn_pkg::AB_W'(v_cur);
    d_nxt = ovn_pkg::D_W'(b_val) - ovn_pkg::D_W'(a_nxt);
  end

  always_comb begin
    state_nxt     = state_r;
    xi_nxt        = xi_r;
    oct_nxt       = oct_r;
    oct_lim_nxt   = oct_lim_r;
    pt_nxt        = pt_r;
    x_nxt         = x_r;
    v_nxt         = v_r;
    total_nxt     = total_r;
    rnd_nxt       = rnd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ovn_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ovn_pkg::ST_PREP;
        end
      end
      ovn_pkg::ST_PREP: begin
        xi_nxt    = ovn_pkg::XI_W'($signed(position_r)) + ovn_pkg::XI_W'(offset_r);
        oct_nxt   = '0;
        pt_nxt    = '0;
        total_nxt = '0;
        if (32'(oct_cnt_r) > ovn_pkg::MAX_OCT) begin
          oct_lim_nxt = ovn_pkg::OCT_W'(ovn_pkg::MAX_OCT);
        end else begin
          oct_lim_nxt = ovn_pkg::OCT_W'(oct_cnt_r);
        end
        // With no octave to sum the result is just center.
        if (oct_cnt_r == 4'd0) begin
          state_nxt = ovn_pkg::ST_SCALE;
        end else begin
          state_nxt = ovn_pkg::ST_SQ;
        end
      end
      ovn_pkg::ST_SQ: begin
        if (pt_r != 2'd0) begin
          v_nxt[pt_r - 2'd1] = v_cur;
        end
        x_nxt     = x_cur;
        state_nxt = ovn_pkg::ST_K;
      end
      ovn_pkg::ST_K: begin
        state_nxt = ovn_pkg::ST_X;
      end
      ovn_pkg::ST_X: begin
        pt_nxt = pt_r + 2'd1;
        if (pt_r == 2'd3) begin
          state_nxt = ovn_pkg::ST_AB;
        end else begin
          state_nxt = ovn_pkg::ST_SQ;
        end
      end
      ovn_pkg::ST_AB: begin
        state_nxt = ovn_pkg::ST_MIX;
      end
      ovn_pkg::ST_MIX: begin
        state_nxt = ovn_pkg::ST_ACC;
      end
      ovn_pkg::ST_ACC: begin
        total_nxt = total_r + ovn_pkg::TOT_W'(mix_sh);
        xi_nxt    = xi_r <<< 1;
        oct_nxt   = oct_inc;
        if (oct_inc == oct_lim_r) begin
          state_nxt = ovn_pkg::ST_SCALE;
        end else begin
          state_nxt = ovn_pkg::ST_SQ;
        end
      end
      ovn_pkg::ST_SCALE: begin
        state_nxt = ovn_pkg::ST_RND;
      end
      ovn_pkg::ST_RND: begin
        rnd_nxt   = rsum[ovn_pkg::RND_W+29:30];
        state_nxt = ovn_pkg::ST_FIN;
      end
      ovn_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat;
          state_nxt     = ovn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ovn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      scale_r    <= 32'sd65536;
      center_r   <= '0;
      oct_cnt_r  <= 4'd8;
      position_r <= '0;
    end else begin
      if (accept) begin
        position_r <= position_r + step_r;
      end
      if (cfg_we) begin
        case (cfg_index)
          ovn_pkg::CFG_STEP_SIZE:      step_r    <= cfg_data;
          ovn_pkg::CFG_SCALE:          scale_r   <= cfg_data;
          ovn_pkg::CFG_CENTER:         center_r  <= cfg_data;
          ovn_pkg::CFG_START_POSITION: position_r <= cfg_data;
          ovn_pkg::CFG_OCTAVE_COUNT:   oct_cnt_r <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      offset_r <= in_sample_offset;
    end
    xi_r       <= xi_nxt;
    x_r        <= x_nxt;
    v_r        <= v_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    total_r    <= total_nxt;
    prod_r     <= prod_nxt;
    rnd_r      <= rnd_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r     <= '0;
      oct_lim_r <= '0;
      pt_r      <= '0;
    end else begin
      oct_r     <= oct_nxt;
      oct_lim_r <= oct_lim_nxt;
      pt_r      <= pt_nxt;
    end
  end

  // A taken request closes the input until the sequence returns to idle.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input still ready after a request was taken");

  // Smoothing only follows the last of the four hashes.
  a_ab_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ovn_pkg::ST_AB) |-> (pt_r == 2'd0 && $past(state_r) == ovn_pkg::ST_X))
    else $error("smoothing step entered out of order");

  a_oct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ovn_pkg::ST_SQ || state_r == ovn_pkg::ST_K || state_r == ovn_pkg::ST_X ||
     state_r == ovn_pkg::ST_AB || state_r == ovn_pkg::ST_MIX || state_r == ovn_pkg::ST_ACC)
    |-> (oct_r < oct_lim_r))
    else $error("octave counter beyond limit");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ovn_pkg::ST_FIN))
    else $error("result raised outside the final step");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ovn_pkg::ST_FIN && out_valid_r && !out_ready) |=> (state_r == ovn_pkg::ST_FIN))
    else $error("finished result overwrote a pending one");

endmodule
